FILE: hdl/prs_pkg.sv
// Package for the probe retry supervisor: field widths, codes, register map,
// configuration and result structs, engine state type.
// No dependencies.
package prs_pkg;

    localparam int NUM_SENSORS_DEF = 4;
    localparam int TIME_BITS_DEF   = 48;

    localparam int SENSOR_IDX_W = 2;
    localparam int KIND_W       = 2;
    localparam int ACTION_W     = 2;
    localparam int COUNT_W      = 4;
    localparam int CFG_INDEX_W  = 8;
    localparam int CFG_DATA_W   = 32;
    localparam int DELAY_W      = 32;
    // base shifted left by up to 14 places
    localparam int BACKOFF_W    = DELAY_W + 15;
    localparam int M_TDATA_W    = 16;

    localparam logic [COUNT_W-1:0] ATTEMPT_MAX = 4'd15;

    // sensor isolation state (s_tuser)
    localparam logic [KIND_W-1:0] SS_EXCLUDED   = 2'd0;
    localparam logic [KIND_W-1:0] SS_PROBING    = 2'd1;
    localparam logic [KIND_W-1:0] SS_VALIDATING = 2'd2;
    localparam logic [KIND_W-1:0] SS_OTHER      = 2'd3;

    // result action
    localparam logic [ACTION_W-1:0] ACT_NONE     = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_START    = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_ABANDON  = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_EVALUATE = 2'd3;

    // register map
    localparam logic [CFG_INDEX_W-1:0] REG_PROBE_TIMEOUT = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ATTEMPT_LIMIT = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_BACKOFF_BASE  = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_BACKOFF_CAP   = 8'd3;

    localparam logic [DELAY_W-1:0] PROBE_TIMEOUT_RST = 32'd2000000;
    localparam logic [COUNT_W-1:0] ATTEMPT_LIMIT_RST = 4'd5;
    localparam logic [DELAY_W-1:0] BACKOFF_BASE_RST  = 32'd1000000;
    localparam logic [DELAY_W-1:0] BACKOFF_CAP_RST   = 32'd30000000;

    typedef struct packed {
        logic [DELAY_W-1:0] probe_timeout_us;
        logic [COUNT_W-1:0] attempt_limit;
        logic [DELAY_W-1:0] backoff_base_us;
        logic [DELAY_W-1:0] backoff_cap_us;
    } cfg_t;

    // last member sits in the lowest bits
    typedef struct packed {
        logic               bookkeeping_cleared;
        logic [COUNT_W-1:0] attempt_count;
        logic               latched_failed;
        logic               timed_out;
        logic [ACTION_W-1:0] action;
    } result_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_COMMIT
    } eng_state_t;

endpackage

FILE: hdl/probe_retry_supervisor_top.sv
// Top level of the probe retry supervisor: port packing and instances of
// the register bank, sensor memory and event engine. Depends on prs_pkg.
//
//  channel   | direction | handshake          | payload
//  ----------+-----------+--------------------+------------------------------------
//  s_        | in        | s_tvalid/s_tready  | s_tdata event fields, s_tuser state
//  m_        | out       | m_tvalid/m_tready  | m_tdata result fields
//  cfg_      | in        | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// An event goes through accept with memory read, evaluate (elapsed time,
// gate, attempt count, backoff shift) and commit (cap, deadline add, write-back
// and result load). The single memory read-modify-write keeps these in series.
// A result waiting in the output register does not block the next accept;
// commit waits while that register is full and m_tready is low.
// Reset is synchronous; per-sensor valid bits clear together, no sweep.
// cfg_ready is always high.
module probe_retry_supervisor_top #(
    parameter int NUM_SENSORS = prs_pkg::NUM_SENSORS_DEF,
    parameter int TIME_BITS   = prs_pkg::TIME_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // sensor_index [1:0], event_time, probe_healthy, zero pad
    input  logic [((TIME_BITS + prs_pkg::SENSOR_IDX_W + 8) / 8) * 8 - 1:0] s_tdata,
    // sensor_state [1:0]
    input  logic [prs_pkg::KIND_W-1:0]          s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // action [1:0], timed_out [2], latched_failed [3], attempt_count [7:4],
    // bookkeeping_cleared [8], zero pad
    output logic [prs_pkg::M_TDATA_W-1:0]       m_tdata,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [prs_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [prs_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import prs_pkg::*;

    localparam int AW = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;
    localparam int EW = 2 * TIME_BITS + COUNT_W + 1;

    cfg_t    cfg;
    result_t m_result;

    logic [SENSOR_IDX_W-1:0] in_idx;
    logic [TIME_BITS-1:0]    in_time;
    logic                    in_healthy;

    logic          rd_en, wr_en;
    logic [AW-1:0] rd_addr, wr_addr;
    logic [EW-1:0] rd_data, wr_data;

    assign in_idx     = s_tdata[SENSOR_IDX_W-1:0];
    assign in_time    = s_tdata[SENSOR_IDX_W +: TIME_BITS];
    assign in_healthy = s_tdata[SENSOR_IDX_W + TIME_BITS];
    assign m_tdata    = M_TDATA_W'(m_result);

    prs_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    prs_state_mem #(
        .NUM_SENSORS (NUM_SENSORS),
        .EW          (EW)
    ) u_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    prs_engine #(
        .NUM_SENSORS (NUM_SENSORS),
        .TIME_BITS   (TIME_BITS)
    ) u_engine (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .in_idx     (in_idx),
        .in_kind    (s_tuser),
        .in_time    (in_time),
        .in_healthy (in_healthy),
        .cfg        (cfg),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_result   (m_result)
    );

endmodule

FILE: hdl/prs_cfg_regs.sv
// Configuration register bank of the probe retry supervisor.
// Depends on prs_pkg.
module prs_cfg_regs (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [prs_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [prs_pkg::CFG_DATA_W-1:0]  cfg_data,
    output prs_pkg::cfg_t                   cfg
);
    import prs_pkg::*;

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.probe_timeout_us <= PROBE_TIMEOUT_RST;
            cfg_reg.attempt_limit    <= ATTEMPT_LIMIT_RST;
            cfg_reg.backoff_base_us  <= BACKOFF_BASE_RST;
            cfg_reg.backoff_cap_us   <= BACKOFF_CAP_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_PROBE_TIMEOUT: cfg_reg.probe_timeout_us <= cfg_data[DELAY_W-1:0];
                REG_ATTEMPT_LIMIT: cfg_reg.attempt_limit    <= cfg_data[COUNT_W-1:0];
                REG_BACKOFF_BASE:  cfg_reg.backoff_base_us  <= cfg_data[DELAY_W-1:0];
                REG_BACKOFF_CAP:   cfg_reg.backoff_cap_us   <= cfg_data[DELAY_W-1:0];
                default: ;
            endcase
        end
    end

endmodule

FILE: hdl/prs_state_mem.sv
// Per-sensor bookkeeping memory: one entry per sensor, registered read,
// per-entry valid bits so an unwritten entry reads as all zero.
// Depends on prs_pkg.
module prs_state_mem #(
    parameter int NUM_SENSORS = prs_pkg::NUM_SENSORS_DEF,
    parameter int EW          = 2 * prs_pkg::TIME_BITS_DEF + 5,
    localparam int AW         = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [EW-1:0] rd_data,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [EW-1:0] wr_data
);
    import prs_pkg::*;

    logic [EW-1:0]          mem [NUM_SENSORS];
    logic [NUM_SENSORS-1:0] valid_reg;
    logic [EW-1:0]          rd_data_reg;
    logic                   rd_valid_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

FILE: hdl/prs_engine.sv
// Event engine: read-modify-write sequencer over the sensor memory, timeout
// and backoff datapath, result output register.
// Depends on prs_pkg.
module prs_engine #(
    parameter int NUM_SENSORS = prs_pkg::NUM_SENSORS_DEF,
    parameter int TIME_BITS   = prs_pkg::TIME_BITS_DEF,
    localparam int AW         = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1,
    localparam int EW         = 2 * TIME_BITS + prs_pkg::COUNT_W + 1
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [prs_pkg::SENSOR_IDX_W-1:0] in_idx,
    input  logic [prs_pkg::KIND_W-1:0]       in_kind,
    input  logic [TIME_BITS-1:0]             in_time,
    input  logic                             in_healthy,
    input  prs_pkg::cfg_t                    cfg,
    output logic                             rd_en,
    output logic [AW-1:0]                    rd_addr,
    input  logic [EW-1:0]                    rd_data,
    output logic                             wr_en,
    output logic [AW-1:0]                    wr_addr,
    output logic [EW-1:0]                    wr_data,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output prs_pkg::result_t                 m_result
);
    import prs_pkg::*;

    localparam int DL_LO  = TIME_BITS;
    localparam int ATT_LO = 2 * TIME_BITS;
    localparam int FL_BIT = 2 * TIME_BITS + COUNT_W;

    eng_state_t state_reg, state_next;

    // request captured at accept
    logic [SENSOR_IDX_W-1:0] idx_reg;
    logic [KIND_W-1:0]       kind_reg;
    logic [TIME_BITS-1:0]    time_reg;
    logic                    healthy_reg;

    // evaluate stage results
    logic [EW-1:0]        ent_reg;
    logic                 in_range_reg;
    logic                 gate_ok_reg;
    logic                 tmo_reg;
    logic [COUNT_W-1:0]   att_inc_reg;
    logic                 limit_hit_reg;
    logic [BACKOFF_W-1:0] backoff_reg;

    logic                 m_tvalid_reg;
    result_t              m_result_reg;

    logic                 commit_go;

    // evaluate stage logic, memory data valid during ST_EVAL
    logic [TIME_BITS-1:0] ent_start, ent_dl, elapsed;
    logic [COUNT_W-1:0]   ent_att, att_inc, shift_amt;
    logic                 ent_failed;

    always_comb begin
        ent_start  = rd_data[TIME_BITS-1:0];
        ent_dl     = rd_data[DL_LO +: TIME_BITS];
        ent_att    = rd_data[ATT_LO +: COUNT_W];
        ent_failed = rd_data[FL_BIT];
        elapsed    = time_reg - ent_start;
        att_inc    = (ent_att == ATTEMPT_MAX) ? ent_att : ent_att + 4'd1;
        shift_amt  = att_inc - 4'd1;
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            idx_reg     <= in_idx;
            kind_reg    <= in_kind;
            time_reg    <= in_time;
            healthy_reg <= in_healthy;
        end
        if (state_reg == ST_EVAL) begin
            ent_reg       <= rd_data;
            in_range_reg  <= (32'(idx_reg) < NUM_SENSORS);
            gate_ok_reg   <= !ent_failed && (time_reg >= ent_dl);
            tmo_reg       <= elapsed > TIME_BITS'(cfg.probe_timeout_us);
            att_inc_reg   <= att_inc;
            limit_hit_reg <= att_inc >= cfg.attempt_limit;
            backoff_reg   <= BACKOFF_W'(cfg.backoff_base_us) << shift_amt;
        end
    end

    // commit stage: cap, deadline add, new entry and result
    logic [DELAY_W-1:0]   capped;
    logic [TIME_BITS-1:0] dl_new;
    logic [TIME_BITS-1:0] new_start, new_dl;
    logic [COUNT_W-1:0]   new_att;
    logic                 new_failed;
    result_t              res;

    always_comb begin
        capped = (backoff_reg > BACKOFF_W'(cfg.backoff_cap_us)) ? cfg.backoff_cap_us
                                                               : backoff_reg[DELAY_W-1:0];
        dl_new     = time_reg + TIME_BITS'(capped);
        new_start  = ent_reg[TIME_BITS-1:0];
        new_dl     = ent_reg[DL_LO +: TIME_BITS];
        new_att    = ent_reg[ATT_LO +: COUNT_W];
        new_failed = ent_reg[FL_BIT];
        res        = '0;
        case (kind_reg)
            SS_EXCLUDED: begin
                if (gate_ok_reg) begin
                    res.action = ACT_START;
                    new_start  = time_reg;
                end
            end
            SS_PROBING, SS_VALIDATING: begin
                if (tmo_reg) begin
                    res.action    = ACT_ABANDON;
                    res.timed_out = 1'b1;
                    new_att       = att_inc_reg;
                    if (limit_hit_reg) begin
                        new_failed         = 1'b1;
                        res.latched_failed = 1'b1;
                    end else begin
                        new_dl = dl_new;
                    end
                end else begin
                    res.action = ACT_EVALUATE;
                    if (healthy_reg) begin
                        new_att                 = '0;
                        new_dl                  = '0;
                        new_failed              = 1'b0;
                        res.bookkeeping_cleared = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        res.attempt_count = new_att;
        // out-of-range sensor: all fields zero
        if (!in_range_reg) begin
            res = '0;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (s_tvalid) state_next = ST_EVAL;
            ST_EVAL:   state_next = ST_COMMIT;
            ST_COMMIT: if (commit_go) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        s_tready  = (state_reg == ST_IDLE);
        commit_go = (state_reg == ST_COMMIT) && (!m_tvalid_reg || m_tready);
        rd_en     = s_tvalid && s_tready;
        rd_addr   = AW'(in_idx);
        wr_en     = commit_go && in_range_reg;
        wr_addr   = AW'(idx_reg);
        wr_data   = {new_failed, new_att, new_dl, new_start};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (commit_go) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (commit_go) begin
            m_result_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_result = m_result_reg;

    // a new result only comes out of the commit step
    a_result_from_commit: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == ST_COMMIT))
        else $error("result raised outside commit");

    // write-back ends the item, so the next read sees it
    a_write_then_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |=> state_reg == ST_IDLE)
        else $error("memory write not followed by idle");

    a_latch_is_timeout: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && m_result_reg.latched_failed |->
            m_result_reg.timed_out && m_result_reg.action == ACT_ABANDON)
        else $error("latch reported without timeout");

    a_clear_on_evaluate: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && m_result_reg.bookkeeping_cleared |->
            m_result_reg.action == ACT_EVALUATE && m_result_reg.attempt_count == '0)
        else $error("bookkeeping cleared outside healthy evaluation");

    a_no_read_while_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_en |-> !wr_en && state_reg == ST_IDLE)
        else $error("memory read overlaps a pending item");

endmodule
